>>> src/lage_pkg.sv
// Shared types and constants for the life grid engine.
// Holds payload structs, operation and register codes, and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lage_pkg;

  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int RowAw   = $clog2(MaxRows);
  localparam int ColAw   = $clog2(MaxCols);
  localparam int CntW    = RowAw + 1;
  localparam int CfgW    = 7;
  localparam int CfgIdxW = 1;

  typedef enum logic [2:0] {
    FUNC_WRITE   = 3'd0,
    FUNC_TOGGLE  = 3'd1,
    FUNC_CLEAR   = 3'd2,
    FUNC_READ    = 3'd3,
    FUNC_ADVANCE = 3'd4
  } lage_func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROWS_IN_USE    = 1'b0,
    CFG_COLUMNS_IN_USE = 1'b1
  } lage_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL,
    ST_ADV_LOAD,
    ST_ADV_ROW,
    ST_DONE
  } lage_state_e;

  typedef struct packed {
    logic [2:0] func;
    logic [5:0] cell_row;
    logic [5:0] cell_column;
    logic       write_value;
  } lage_in_t;

  typedef struct packed {
    logic [2:0] done_func;
    logic       read_value;
    logic       out_of_range;
  } lage_out_t;

endpackage

`default_nettype wire

>>> src/lage_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lage_ram #(
  parameter int Width = 64,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/lage_row_rule.sv
// Shared row unit: applies the B3/S23 rule to one row word from its
// neighbor rows. Depends on lage_pkg for the row width.
`timescale 1ns / 1ps
`default_nettype none

module lage_row_rule import lage_pkg::*; (
  input  logic [MaxCols-1:0] prev_i,
  input  logic [MaxCols-1:0] cur_i,
  input  logic [MaxCols-1:0] below_i,
  input  logic [MaxCols-1:0] mask_i,
  output logic [MaxCols-1:0] fresh_o
);

  logic [MaxCols+1:0] p_pad;
  logic [MaxCols+1:0] c_pad;
  logic [MaxCols+1:0] b_pad;

  // Pad with dead cells so the edges never wrap.
  assign p_pad = {1'b0, prev_i & mask_i, 1'b0};
  assign c_pad = {1'b0, cur_i & mask_i, 1'b0};
  assign b_pad = {1'b0, below_i & mask_i, 1'b0};

  always_comb begin
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < MaxCols; k++) begin
      n = 4'(p_pad[k]) + 4'(p_pad[k+1]) + 4'(p_pad[k+2])
        + 4'(c_pad[k]) + 4'(c_pad[k+2])
        + 4'(b_pad[k]) + 4'(b_pad[k+1]) + 4'(b_pad[k+2]);
      fresh_o[k] = mask_i[k] & ((n == 4'd3) | (c_pad[k+1] & (n == 4'd2)));
    end
  end

endmodule

`default_nettype wire

>>> src/life_automaton_grid_engine_top.sv
// Sequence: write, toggle and read pass ST_CELL, then ST_DONE (straight to ST_DONE when
// out of range); clear and unused codes go straight to ST_DONE; advance passes ST_ADV_LOAD,
// then ST_ADV_ROW once per row in use, then ST_DONE (directly when no row is in use).
// One item at a time: the next beat is taken once back in ST_IDLE after the result is loaded.
// Advance runs one row word per cycle through the shared row unit and row memory.
// Reset: asynchronous active low; all cells dead (per-row valid bits), registers at 64.
`timescale 1ns / 1ps
`default_nettype none

module life_automaton_grid_engine_top import lage_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lage_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lage_out_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  lage_state_e        state_q, state_d;
  logic [CfgW-1:0]    rows_cfg_q, cols_cfg_q;
  logic [CfgW-1:0]    rows_eff, cols_eff;
  logic [MaxCols-1:0] col_mask;
  logic [MaxRows-1:0] row_vld_q, row_vld_d;
  lage_in_t           item_q, item_d;
  logic               oor_q, oor_d;
  logic               rv_q, rv_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    idx_inc, idx_inc2;
  logic [MaxCols-1:0] prev_q, prev_d;
  logic [MaxCols-1:0] cur_q, cur_d;
  logic               vld_rd_q;
  logic               ram_we;
  logic [RowAw-1:0]   ram_waddr, ram_raddr;
  logic [MaxCols-1:0] ram_wdata, ram_rdata;
  logic [MaxCols-1:0] rd_word, below_word, fresh, cell_word;
  logic               out_valid_q, out_valid_d;
  lage_out_t          out_q, out_d;
  logic               addr_oor;
  logic               out_free;

  assign rows_eff = (rows_cfg_q > CfgW'(MaxRows)) ? CfgW'(MaxRows) : rows_cfg_q;
  assign cols_eff = (cols_cfg_q > CfgW'(MaxCols)) ? CfgW'(MaxCols) : cols_cfg_q;

  always_comb begin
    for (int k = 0; k < MaxCols; k++) begin
      col_mask[k] = CfgW'(k) < cols_eff;
    end
  end

  assign addr_oor = (CfgW'(in_data_i.cell_row) >= rows_eff)
                 || (CfgW'(in_data_i.cell_column) >= cols_eff);

  // A row never written since reset or clear reads as all dead.
  assign rd_word    = vld_rd_q ? ram_rdata : '0;
  assign idx_inc    = idx_q + CntW'(1);
  assign idx_inc2   = idx_q + CntW'(2);
  assign below_word = (idx_inc < CntW'(rows_eff)) ? rd_word : '0;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cell_word = rd_word;
    case (lage_func_e'(item_q.func))
      FUNC_WRITE:  cell_word[item_q.cell_column] = item_q.write_value;
      FUNC_TOGGLE: cell_word[item_q.cell_column] = ~rd_word[item_q.cell_column];
      default:     cell_word = rd_word;
    endcase
  end

  lage_ram #(
    .Width(MaxCols),
    .Depth(MaxRows)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  lage_row_rule u_rule (
    .prev_i (prev_q),
    .cur_i  (cur_q),
    .below_i(below_word),
    .mask_i (col_mask),
    .fresh_o(fresh)
  );

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    oor_d     = oor_q;
    rv_d      = rv_q;
    idx_d     = idx_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    row_vld_d = row_vld_q;
    ram_we    = 1'b0;
    ram_waddr = item_q.cell_row;
    ram_wdata = cell_word;
    ram_raddr = in_data_i.cell_row;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          oor_d  = 1'b0;
          rv_d   = 1'b0;
          idx_d  = '0;
          if (in_data_i.func inside {FUNC_WRITE, FUNC_TOGGLE, FUNC_READ}) begin
            if (addr_oor) begin
              oor_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              state_d = ST_CELL;
            end
          end else if (in_data_i.func == FUNC_CLEAR) begin
            row_vld_d = '0;
            state_d   = ST_DONE;
          end else if (in_data_i.func == FUNC_ADVANCE) begin
            ram_raddr = '0;
            state_d   = (rows_eff == '0) ? ST_DONE : ST_ADV_LOAD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CELL: begin
        rv_d = cell_word[item_q.cell_column];
        if (item_q.func != FUNC_READ) begin
          ram_we                     = 1'b1;
          row_vld_d[item_q.cell_row] = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_ADV_LOAD: begin
        cur_d     = rd_word;
        prev_d    = '0;
        ram_raddr = RowAw'(1);
        state_d   = ST_ADV_ROW;
      end
      ST_ADV_ROW: begin
        // Rewrite this row in place; the row below was read before this write.
        ram_we    = 1'b1;
        ram_waddr = idx_q[RowAw-1:0];
        ram_wdata = (cur_q & ~col_mask) | fresh;
        row_vld_d[idx_q[RowAw-1:0]] = 1'b1;
        ram_raddr = idx_inc2[RowAw-1:0];
        prev_d    = cur_q;
        cur_d     = below_word;
        idx_d     = idx_inc;
        if (idx_inc >= CntW'(rows_eff)) begin
          prev_d  = '0;
          cur_d   = '0;
          idx_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (state_q == ST_DONE && out_free) begin
      out_valid_d        = 1'b1;
      out_d.done_func    = item_q.func;
      out_d.read_value   = rv_q;
      out_d.out_of_range = oor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_vld_q   <= '0;
      idx_q       <= '0;
      prev_q      <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      rows_cfg_q  <= CfgW'(MaxRows);
      cols_cfg_q  <= CfgW'(MaxCols);
      vld_rd_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_vld_q   <= row_vld_d;
      idx_q       <= idx_d;
      prev_q      <= prev_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      vld_rd_q    <= row_vld_q[ram_raddr];
      if (cfg_we_i) begin
        case (lage_cfg_e'(cfg_idx_i))
          CFG_ROWS_IN_USE:    rows_cfg_q <= cfg_wdata_i;
          CFG_COLUMNS_IN_USE: cols_cfg_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    oor_q  <= oor_d;
    rv_q   <= rv_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != ST_IDLE)
    else $error("accepted beat did not start work");

  a_walk_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADV_ROW |-> idx_q < CntW'(rows_eff))
    else $error("row walk past rows in use");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result beat without finished item");

  a_write_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CELL || state_q == ST_ADV_ROW))
    else $error("row memory written outside of work");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.func == FUNC_CLEAR |=> row_vld_q == '0)
    else $error("clear left live rows");
`endif

endmodule

`default_nettype wire
